[rtl/pud_pkg.sv]
`default_nettype none

package pud_pkg;

    localparam int COUNT_BITS = 24;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
    localparam int MAX_OUT    = 3;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] bytes;
        logic [1:0]              cnt;
        logic                    last;
    } pkt_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66)
            || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

    function automatic logic is_text(input logic [7:0] b);
        return (b >= 8'h20 && b <= 8'h7E) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

endpackage

`default_nettype wire

[rtl/pud_front.sv]
`default_nettype none

module pud_front
    import pud_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // in_byte
    input  wire logic       s_tlast,   // in_last
    input  wire logic       queue_full,
    output logic            push,
    output pkt_t            pkt
);

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;

    logic [MAX_OUT-1:0][7:0] b;
    logic [1:0]              n;
    logic                    accept;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && (n != 2'd0);

    always_comb begin
        b          = '0;
        n          = 2'd0;
        phase_next = PH_IDLE;
        held_next  = held_reg;
        unique case (phase_reg)
            PH_IDLE: begin
                if (s_tdata == CH_PCT) begin
                    phase_next = PH_PCT;
                end else begin
                    b[n] = (s_tdata == CH_PLUS) ? CH_SPACE : s_tdata;
                    n    = n + 2'd1;
                end
            end
            PH_PCT: begin
                if (is_hex(s_tdata)) begin
                    held_next  = s_tdata;
                    phase_next = PH_DIGIT;
                end else begin
                    b[n] = CH_PCT;
                    n    = n + 2'd1;
                    if (s_tdata == CH_PCT) begin
                        phase_next = PH_PCT;
                    end else begin
                        b[n] = (s_tdata == CH_PLUS) ? CH_SPACE : s_tdata;
                        n    = n + 2'd1;
                    end
                end
            end
            PH_DIGIT: begin
                if (is_hex(s_tdata)) begin
                    b[n] = {hex_val(held_reg), hex_val(s_tdata)};
                    n    = n + 2'd1;
                end else begin
                    b[n] = CH_PCT;
                    n    = n + 2'd1;
                    b[n] = held_reg;
                    n    = n + 2'd1;
                    if (s_tdata == CH_PCT) begin
                        phase_next = PH_PCT;
                    end else begin
                        b[n] = (s_tdata == CH_PLUS) ? CH_SPACE : s_tdata;
                        n    = n + 2'd1;
                    end
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
        // flush whatever is held at end of buffer
        if (s_tlast) begin
            if (phase_next == PH_PCT) begin
                b[n] = CH_PCT;
                n    = n + 2'd1;
            end else if (phase_next == PH_DIGIT) begin
                b[n] = CH_PCT;
                n    = n + 2'd1;
                b[n] = held_next;
                n    = n + 2'd1;
            end
            phase_next = PH_IDLE;
            held_next  = 8'd0;
        end
    end

    assign pkt.bytes = b;
    assign pkt.cnt   = n;
    assign pkt.last  = s_tlast;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

`default_nettype wire

[rtl/pud_fifo.sv]
`default_nettype none

module pud_fifo
    import pud_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire pkt_t wr_pkt,
    input  wire logic pop,
    output pkt_t      rd_pkt,
    output logic      full,
    output logic      not_empty
);

    pkt_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg;
    logic               do_push, do_pop;

    assign full      = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign rd_pkt    = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wr_pkt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/pud_back.sv]
`default_nettype none

module pud_back
    import pud_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire pkt_t       head,
    input  wire logic       head_valid,
    output logic            pop,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // out_byte
    output logic            m_tlast,   // out_last
    output logic            m_tuser,   // accepted
    output logic [1:0]      idx
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [1:0]            idx_reg;
    logic [COUNT_BITS-1:0] emitted_reg, emitted_next;
    logic [COUNT_BITS-1:0] printable_reg, printable_next;
    logic                  valid_reg;
    logic [7:0]            data_reg;
    logic                  last_reg, acc_reg;

    logic [7:0]            cur;
    logic                  is_end, load, end_of_buf;
    logic [COUNT_BITS+2:0] p5, e2;

    assign cur        = head.bytes[idx_reg];
    assign is_end     = (idx_reg + 2'd1 == head.cnt);
    assign load       = head_valid && (!valid_reg || m_tready);
    assign pop        = load && is_end;
    assign end_of_buf = head.last && is_end;
    assign idx        = idx_reg;

    always_comb begin
        emitted_next   = (emitted_reg != CNT_MAX) ? emitted_reg + 1'b1 : emitted_reg;
        printable_next = printable_reg;
        if (is_text(cur) && printable_reg != CNT_MAX) begin
            printable_next = printable_reg + 1'b1;
        end
        p5 = {1'b0, printable_next, 2'b00} + {3'b000, printable_next};
        e2 = {2'b00, emitted_next, 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= cur;
            last_reg <= end_of_buf;
            acc_reg  <= end_of_buf && !(p5 < e2);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            idx_reg       <= 2'd0;
            emitted_reg   <= '0;
            printable_reg <= '0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= is_end ? 2'd0 : idx_reg + 2'd1;
                if (end_of_buf) begin
                    emitted_reg   <= '0;
                    printable_reg <= '0;
                end else begin
                    emitted_reg   <= emitted_next;
                    printable_reg <= printable_next;
                end
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = acc_reg;

endmodule

`default_nettype wire

[rtl/percent_url_decoder_core.sv]
// URL percent decoder, streaming.
// Input channel s_*: one raw byte per request in s_tdata, s_tlast on the
// final byte of a buffer. Output channel m_*: one decoded byte per request,
// m_tlast on the final decoded byte, m_tuser on that byte set when at least
// 0.4 of the decoded bytes are printable or whitespace (counters saturate).
// Each input byte yields 0 to 3 output bytes ("%XY" one byte, broken or
// cut-off escapes pass through literally).
// The first result of an accepted input request passes the queue write,
// then the output register. Throughput: one input request per cycle while
// the 4-entry packet queue has room; the output side drains one byte per
// cycle while m_tready is high, so the sustained rate is set by the single
// output register.
// Reset (aresetn low, synchronous) empties the queue, drops any held escape
// and clears the counters. A stalled receiver holds m_* steady; the queue
// then fills and s_tready drops.
`default_nettype none

module percent_url_decoder_core
    import pud_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // in_byte
    input  wire logic       s_tlast,   // in_last
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // out_byte
    output logic            m_tlast,   // out_last
    output logic            m_tuser    // accepted
);

    pkt_t       wr_pkt, head;
    logic       push, pop, full, not_empty;
    logic [1:0] idx;

    pud_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_full (full),
        .push       (push),
        .pkt        (wr_pkt)
    );

    pud_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .wr_pkt    (wr_pkt),
        .pop       (pop),
        .rd_pkt    (head),
        .full      (full),
        .not_empty (not_empty)
    );

    pud_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (not_empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .idx        (idx)
    );

    a_flag_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("accept flag outside final byte");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !s_tready)
        else $error("input taken while queue full");

    a_idx_in_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        not_empty |-> (idx < head.cnt))
        else $error("byte index past packet end");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

`default_nettype wire
